FILE: hdl/mp2d_pkg.sv
// shared types, register codes and limits for the streaming max pooling block
package mp2d_pkg;

	localparam int MAX_WIDTH_DEF   = 1024;
	localparam int MAX_WINDOW_DEF  = 4;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int FRAME_LIMIT = 1024;
	localparam int STEP_LIMIT  = 4;

	localparam int DIM_BITS   = 11;
	localparam int WS_BITS    = 3;
	localparam int POS_BITS   = 10;
	localparam int PH_BITS    = 2;
	localparam int VALUE_BITS = 16;
	localparam int IDX_BITS   = 2;

	localparam logic [IDX_BITS-1:0] REG_HEIGHT = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_WIDTH  = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_WINDOW = 2'd2;
	localparam logic [IDX_BITS-1:0] REG_STEP   = 2'd3;

	localparam logic [DIM_BITS-1:0] HEIGHT_RST = 11'd32;
	localparam logic [DIM_BITS-1:0] WIDTH_RST  = 11'd32;
	localparam logic [WS_BITS-1:0]  WINDOW_RST = 3'd2;
	localparam logic [WS_BITS-1:0]  STEP_RST   = 3'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_FINISH
	} mp2d_state_t;

endpackage

FILE: hdl/max_pool_2d_stream.sv
// streaming 2-d max pooling: line store, window scan sequencer, result register
// A sample that does not close a pooling window is accepted without a scan. A sample that
// closes a window starts a scan: the window is read from the line store one entry per cycle
// through its single read port, and one shared comparator folds each entry into the running
// maximum; sample_ready stays low while the window is being scanned. The result sits
// in an output register, so the next sample is taken while it waits; a later scan holds in
// its last cycle, with sample_ready low, until that register is free. The line store holds
// MAX_WINDOW rows of MAX_WIDTH samples, is not cleared, and is only read where written.
// Configuration writes are held off during a scan and restart the frame at row 0, column 0.
module max_pool_2d_stream #(
	parameter int MAX_WIDTH   = mp2d_pkg::MAX_WIDTH_DEF,
	parameter int MAX_WINDOW  = mp2d_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = mp2d_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mp2d_pkg::IDX_BITS-1:0]       cfg_index,
	input  logic [mp2d_pkg::DIM_BITS-1:0]       cfg_data,
	input  logic                                sample_valid,
	output logic                                sample_ready,
	input  logic signed [SAMPLE_BITS-1:0]       sample,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic signed [mp2d_pkg::VALUE_BITS-1:0] pooled_value,
	output logic [mp2d_pkg::POS_BITS-1:0]       out_row,
	output logic [mp2d_pkg::POS_BITS-1:0]       out_col,
	output logic                                frame_last
);
	import mp2d_pkg::*;

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RSW  = $clog2(MAX_WINDOW);
	localparam int WLIM = (MAX_WIDTH < FRAME_LIMIT) ? MAX_WIDTH : FRAME_LIMIT;
	localparam int WIDE = (SAMPLE_BITS > VALUE_BITS) ? SAMPLE_BITS : VALUE_BITS;

	// configuration
	logic [DIM_BITS-1:0] height_q, width_q;
	logic [WS_BITS-1:0]  window_q, step_q;
	logic [DIM_BITS-1:0] h_eff, w_eff;
	logic [WS_BITS-1:0]  ws_eff, st_eff, ws_m1;

	// position and phase tracking
	logic [POS_BITS-1:0] r_q, c_q, rqt_q, cqt_q;
	logic [PH_BITS-1:0]  rph_q, cph_q;
	logic [RSW-1:0]      rs_q;

	// scan sequencer
	mp2d_state_t state_q, state_d;
	logic [RSW-1:0]      sc_row_q;
	logic [CW-1:0]       sc_col_q, cb_q;
	logic [WS_BITS-1:0]  sc_m_q, sc_n_q;
	logic                first_q, rd_vld_s1;
	logic signed [SAMPLE_BITS-1:0] rd_q, best_q;
	logic [POS_BITS-1:0] pend_row_q, pend_col_q;
	logic                pend_last_q;
	logic                res_valid_q;

	logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW][MAX_WIDTH];

	logic cfg_acc, acc, emit, is_last, elig_r, elig_c, c_wrap, r_wrap;
	logic scan_last, rd_en, fin, out_load, take;
	logic [DIM_BITS-1:0] c_inc, r_inc, cb_full;
	logic [RSW:0]        rb_tmp;
	logic [RSW-1:0]      rb;
	logic [CW-1:0]       wr_col;
	logic signed [SAMPLE_BITS-1:0] final_max;
	logic signed [WIDE-1:0]        final_ext;

	assign cfg_ready = (state_q == ST_IDLE);
	assign cfg_acc   = cfg_valid && cfg_ready;

	always_comb begin
		if (height_q == '0) h_eff = DIM_BITS'(1);
		else if (height_q > DIM_BITS'(FRAME_LIMIT)) h_eff = DIM_BITS'(FRAME_LIMIT);
		else h_eff = height_q;
		if (width_q == '0) w_eff = DIM_BITS'(1);
		else if (width_q > DIM_BITS'(WLIM)) w_eff = DIM_BITS'(WLIM);
		else w_eff = width_q;
		if (window_q == '0) ws_eff = WS_BITS'(1);
		else if (int'(window_q) > MAX_WINDOW) ws_eff = WS_BITS'(MAX_WINDOW);
		else ws_eff = window_q;
		if (step_q == '0) st_eff = WS_BITS'(1);
		else if (step_q > WS_BITS'(STEP_LIMIT)) st_eff = WS_BITS'(STEP_LIMIT);
		else st_eff = step_q;
	end

	assign ws_m1   = ws_eff - WS_BITS'(1);
	assign c_inc   = {1'b0, c_q} + DIM_BITS'(1);
	assign r_inc   = {1'b0, r_q} + DIM_BITS'(1);
	assign c_wrap  = c_inc >= w_eff;
	assign r_wrap  = r_inc >= h_eff;
	assign elig_c  = c_inc >= DIM_BITS'(ws_eff);
	assign elig_r  = r_inc >= DIM_BITS'(ws_eff);
	assign emit    = elig_r && elig_c && (rph_q == '0) && (cph_q == '0);
	assign is_last = (({1'b0, r_q} + DIM_BITS'(st_eff)) >= h_eff)
		&& (({1'b0, c_q} + DIM_BITS'(st_eff)) >= w_eff);
	assign cb_full = c_inc - DIM_BITS'(ws_eff);
	assign rb_tmp  = (RSW+1)'(rs_q) + (RSW+1)'(MAX_WINDOW) - (RSW+1)'(ws_m1);
	assign rb      = (rb_tmp >= (RSW+1)'(MAX_WINDOW)) ? RSW'(rb_tmp - (RSW+1)'(MAX_WINDOW))
		: RSW'(rb_tmp);
	assign wr_col  = CW'(c_q);
	assign scan_last = (sc_m_q == ws_m1) && (sc_n_q == ws_m1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && emit) state_d = ST_READ;
			end
			ST_READ: begin
				if (scan_last) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!res_valid_q || result_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		sample_ready = 1'b0;
		rd_en        = 1'b0;
		fin          = 1'b0;
		case (state_q)
			ST_IDLE:   sample_ready = !cfg_valid;
			ST_READ:   rd_en = 1'b1;
			ST_FINISH: fin = 1'b1;
			default: begin
				sample_ready = 1'b0;
			end
		endcase
	end

	assign acc       = sample_valid && sample_ready;
	assign out_load  = fin && (!res_valid_q || result_ready);
	assign take      = first_q || (rd_q > best_q);
	assign final_max = take ? rd_q : best_q;
	assign final_ext = WIDE'(final_max);

	// line store
	always_ff @(posedge clk) begin
		if (acc) mem[rs_q][wr_col] <= sample;
		if (rd_en) rd_q <= mem[sc_row_q][sc_col_q];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			height_q    <= HEIGHT_RST;
			width_q     <= WIDTH_RST;
			window_q    <= WINDOW_RST;
			step_q      <= STEP_RST;
			r_q         <= '0;
			c_q         <= '0;
			rqt_q       <= '0;
			cqt_q       <= '0;
			rph_q       <= '0;
			cph_q       <= '0;
			rs_q        <= '0;
			rd_vld_s1   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (out_load) res_valid_q <= 1'b1;
			else if (result_ready) res_valid_q <= 1'b0;
			if (cfg_acc) begin
				case (cfg_index)
					REG_HEIGHT: height_q <= cfg_data;
					REG_WIDTH:  width_q  <= cfg_data;
					REG_WINDOW: window_q <= cfg_data[WS_BITS-1:0];
					REG_STEP:   step_q   <= cfg_data[WS_BITS-1:0];
					default:    height_q <= height_q;
				endcase
				r_q   <= '0;
				c_q   <= '0;
				rqt_q <= '0;
				cqt_q <= '0;
				rph_q <= '0;
				cph_q <= '0;
				rs_q  <= '0;
			end else if (acc) begin
				if (c_wrap) begin
					c_q   <= '0;
					cph_q <= '0;
					cqt_q <= '0;
					if (r_wrap) begin
						r_q   <= '0;
						rs_q  <= '0;
						rph_q <= '0;
						rqt_q <= '0;
					end else begin
						r_q  <= r_inc[POS_BITS-1:0];
						rs_q <= (rs_q == RSW'(MAX_WINDOW - 1)) ? '0 : rs_q + RSW'(1);
						if (!elig_r) begin
							rph_q <= '0;
							rqt_q <= '0;
						end else if (({1'b0, rph_q} + WS_BITS'(1)) == st_eff) begin
							rph_q <= '0;
							rqt_q <= rqt_q + POS_BITS'(1);
						end else begin
							rph_q <= rph_q + PH_BITS'(1);
						end
					end
				end else begin
					c_q <= c_inc[POS_BITS-1:0];
					if (!elig_c) begin
						cph_q <= '0;
						cqt_q <= '0;
					end else if (({1'b0, cph_q} + WS_BITS'(1)) == st_eff) begin
						cph_q <= '0;
						cqt_q <= cqt_q + POS_BITS'(1);
					end else begin
						cph_q <= cph_q + PH_BITS'(1);
					end
				end
			end
		end
	end

	// scan and result payload
	always_ff @(posedge clk) begin
		if (acc && emit) begin
			sc_row_q    <= rb;
			sc_col_q    <= CW'(cb_full[POS_BITS-1:0]);
			cb_q        <= CW'(cb_full[POS_BITS-1:0]);
			sc_m_q      <= '0;
			sc_n_q      <= '0;
			first_q     <= 1'b1;
			pend_row_q  <= rqt_q;
			pend_col_q  <= cqt_q;
			pend_last_q <= is_last;
		end else begin
			if (rd_en) begin
				if (sc_n_q == ws_m1) begin
					sc_n_q   <= '0;
					sc_col_q <= cb_q;
					sc_m_q   <= sc_m_q + WS_BITS'(1);
					sc_row_q <= (sc_row_q == RSW'(MAX_WINDOW - 1)) ? '0 : sc_row_q + RSW'(1);
				end else begin
					sc_n_q   <= sc_n_q + WS_BITS'(1);
					sc_col_q <= sc_col_q + CW'(1);
				end
			end
			if (rd_en && rd_vld_s1) begin
				best_q  <= final_max;
				first_q <= 1'b0;
			end
		end
		if (out_load) begin
			pooled_value <= final_ext[VALUE_BITS-1:0];
			out_row      <= pend_row_q;
			out_col      <= pend_col_q;
			frame_last   <= pend_last_q;
		end
	end

	assign result_valid = res_valid_q;

endmodule

FILE: hdl/mp2d_checker.sv
// port-level checks for the streaming max pooling block, bound to its top level
module mp2d_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 cfg_valid,
	input logic                                 sample_valid,
	input logic                                 sample_ready,
	input logic                                 result_valid,
	input logic                                 result_ready,
	input logic signed [mp2d_pkg::VALUE_BITS-1:0] pooled_value,
	input logic [mp2d_pkg::POS_BITS-1:0]        out_row,
	input logic [mp2d_pkg::POS_BITS-1:0]        out_col,
	input logic                                 frame_last
);
	import mp2d_pkg::*;

	// stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(pooled_value)
		&& $stable(out_row) && $stable(out_col) && $stable(frame_last))
		else $error("result beat changed while stalled");

	// with no configuration write pending, ready only drops after a sample beat starts a window scan
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(sample_ready) && !cfg_valid |-> $past(sample_valid && sample_ready))
		else $error("sample_ready dropped without a sample beat");

	// a new result only comes out of a scan, while samples are held off
	a_result_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!sample_ready))
		else $error("result appeared outside a window scan");

endmodule

bind max_pool_2d_stream mp2d_checker u_mp2d_checker (.*);
